[design/onewire_temperature_sensor_master_top_assert.svh]
// Assertion helpers, clocked on clk_i and disabled while rst_ni is low.
`ifndef ONEWIRE_TEMPERATURE_SENSOR_MASTER_TOP_ASSERT_SVH
`define ONEWIRE_TEMPERATURE_SENSOR_MASTER_TOP_ASSERT_SVH

// Same-cycle implication.
`define OWTM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define OWTM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/owtm_pkg.sv]
`default_nettype none
package owtm_pkg;

  localparam int unsigned TICK_W = 7;

  localparam int unsigned RESET_LOW_TICKS_DEF     = 100;
  localparam int unsigned PRESENCE_WAIT_TICKS_DEF = 12;
  localparam int unsigned RECOVERY_WAIT_TICKS_DEF = 50;
  localparam int unsigned SLOT_TICKS_DEF          = 12;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_RST_LOW,
    PH_PRESENCE,
    PH_RECOV_OK,
    PH_RECOV_FAIL,
    PH_GAP_OK,
    PH_GAP_FAIL,
    PH_WRITE,
    PH_READ
  } phase_e;

  typedef enum logic [1:0] {
    CMD_NONE    = 2'd0,
    CMD_CONVERT = 2'd1,
    CMD_READ    = 2'd2,
    CMD_WRITE   = 2'd3
  } cmd_e;

  // config register indexes
  localparam logic CFG_ALARM_WORD = 1'b0;
  localparam logic CFG_SETUP_BYTE = 1'b1;

  localparam logic [15:0] NO_READING  = 16'h7FFF;
  localparam logic [7:0]  SETUP_RESET = 8'd127;

  localparam logic [7:0] BYTE_SKIP_ROM = 8'hCC;
  localparam logic [7:0] BYTE_CONVERT  = 8'h44;
  localparam logic [7:0] BYTE_RD_SCR   = 8'hBE;
  localparam logic [7:0] BYTE_WR_SCR   = 8'h4E;

  localparam logic [2:0] NBYTES_WRITE = 3'd5;
  localparam logic [2:0] NBYTES_SHORT = 3'd2;

  typedef struct packed {
    logic        drive_low;
    logic        busy;
    logic        done;
    logic        present;
    logic [15:0] temperature;
  } res_t;

  // Byte to send at position idx of a transaction of the given kind.
  function automatic logic [7:0] byte_for(logic [1:0] kind, logic [2:0] idx,
                                          logic [15:0] alarm, logic [7:0] setup);
    logic [7:0] b;
    if (idx == 3'd0)              b = BYTE_SKIP_ROM;
    else if (kind == CMD_CONVERT) b = BYTE_CONVERT;
    else if (kind == CMD_READ)    b = BYTE_RD_SCR;
    else if (idx == 3'd1)         b = BYTE_WR_SCR;
    else if (idx == 3'd2)         b = alarm[15:8];
    else if (idx == 3'd3)         b = alarm[7:0];
    else                          b = setup;
    return b;
  endfunction

endpackage
`default_nettype wire

[design/owtm_core.sv]
`default_nettype none
module owtm_core import owtm_pkg::*; #(
  parameter int unsigned RESET_LOW_TICKS     = RESET_LOW_TICKS_DEF,
  parameter int unsigned PRESENCE_WAIT_TICKS = PRESENCE_WAIT_TICKS_DEF,
  parameter int unsigned RECOVERY_WAIT_TICKS = RECOVERY_WAIT_TICKS_DEF,
  parameter int unsigned SLOT_TICKS          = SLOT_TICKS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        step_i,
  input  wire logic [1:0]  command_i,
  input  wire logic        line_level_i,
  input  wire logic [15:0] alarm_word_i,
  input  wire logic [7:0]  setup_byte_i,
  output res_t             res_o
);

  localparam logic [TICK_W-1:0] RstLow   = TICK_W'(RESET_LOW_TICKS);
  localparam logic [TICK_W-1:0] PresWait = TICK_W'(PRESENCE_WAIT_TICKS);
  localparam logic [TICK_W-1:0] RecWait  = TICK_W'(RECOVERY_WAIT_TICKS);
  localparam logic [TICK_W-1:0] Slot     = TICK_W'(SLOT_TICKS);
  localparam logic [TICK_W-1:0] SlotM1   = TICK_W'(SLOT_TICKS - 1);
  localparam logic [TICK_W-1:0] TickOne  = TICK_W'(1);

  phase_e             phase_q, phase_d;
  logic [TICK_W-1:0]  tick_q, tick_d;
  logic [2:0]         bit_q, bit_d;
  logic [2:0]         byte_q, byte_d;
  logic [1:0]         kind_q, kind_d;
  logic [7:0]         shift_q, shift_d;
  logic [15:0]        reading_q, reading_d;
  logic               present_q, present_d;
  logic [7:0]         low_q, low_d;
  logic               drive, done;

  logic [TICK_W-1:0]  tick_inc;
  logic               slot_end;
  logic [2:0]         bit_inc, byte_inc, n_bytes;
  logic [7:0]         rd_shift;

  assign tick_inc = tick_q + TickOne;
  assign slot_end = (tick_inc >= Slot);
  assign bit_inc  = bit_q + 3'd1;
  assign byte_inc = byte_q + 3'd1;
  assign n_bytes  = (kind_q == CMD_WRITE) ? NBYTES_WRITE : NBYTES_SHORT;
  // read sample lands on the second tick of the slot
  assign rd_shift = (tick_q == TickOne && line_level_i) ? (shift_q | (8'd1 << bit_q)) : shift_q;

  // next state
  always_comb begin
    phase_d   = phase_q;
    tick_d    = tick_q;
    bit_d     = bit_q;
    byte_d    = byte_q;
    kind_d    = kind_q;
    shift_d   = shift_q;
    reading_d = reading_q;
    present_d = present_q;
    low_d     = low_q;
    case (phase_q)
      PH_IDLE: begin
        if (command_i != CMD_NONE) begin
          kind_d = command_i;
          tick_d = TickOne;
          if (TickOne >= RstLow) begin
            phase_d = PH_PRESENCE;
            tick_d  = '0;
          end else begin
            phase_d = PH_RST_LOW;
          end
        end
      end
      PH_RST_LOW: begin
        tick_d = tick_inc;
        if (tick_inc >= RstLow) begin
          phase_d = PH_PRESENCE;
          tick_d  = '0;
        end
      end
      PH_PRESENCE: begin
        tick_d = tick_inc;
        if (tick_inc >= PresWait) begin
          phase_d = PH_RECOV_FAIL;
          tick_d  = '0;
        end else if (!line_level_i) begin
          phase_d = PH_RECOV_OK;
          tick_d  = '0;
        end
      end
      PH_RECOV_OK, PH_RECOV_FAIL: begin
        tick_d = tick_inc;
        if (tick_inc >= RecWait) begin
          phase_d = PH_GAP_FAIL;
          tick_d  = '0;
        end else if (line_level_i) begin
          phase_d = (phase_q == PH_RECOV_OK) ? PH_GAP_OK : PH_GAP_FAIL;
          tick_d  = '0;
        end
      end
      PH_GAP_OK: begin
        present_d = 1'b1;
        byte_d    = '0;
        bit_d     = '0;
        tick_d    = '0;
        shift_d   = byte_for(kind_q, 3'd0, alarm_word_i, setup_byte_i);
        phase_d   = PH_WRITE;
      end
      PH_GAP_FAIL: begin
        present_d = 1'b0;
        if (kind_q == CMD_READ) reading_d = NO_READING;
        phase_d = PH_IDLE;
      end
      PH_WRITE: begin
        tick_d = tick_inc;
        if (slot_end) begin
          tick_d  = '0;
          shift_d = shift_q >> 1;
          bit_d   = bit_inc;
          if (bit_inc == 3'd0) begin
            byte_d = byte_inc;
            if (byte_inc >= n_bytes) begin
              if (kind_q == CMD_READ) begin
                byte_d  = '0;
                shift_d = '0;
                phase_d = PH_READ;
              end else begin
                phase_d = PH_IDLE;
              end
            end else begin
              shift_d = byte_for(kind_q, byte_inc, alarm_word_i, setup_byte_i);
            end
          end
        end
      end
      PH_READ: begin
        shift_d = rd_shift;
        tick_d  = tick_inc;
        if (slot_end) begin
          tick_d = '0;
          bit_d  = bit_inc;
          if (bit_inc == 3'd0) begin
            if (byte_q == 3'd0) begin
              low_d   = rd_shift;
              shift_d = '0;
              byte_d  = 3'd1;
            end else begin
              reading_d = {rd_shift, low_q};
              phase_d   = PH_IDLE;
            end
          end
        end
      end
      default: phase_d = PH_IDLE;
    endcase
  end

  // tick outputs
  always_comb begin
    drive = 1'b0;
    done  = 1'b0;
    case (phase_q)
      PH_IDLE:     drive = (command_i != CMD_NONE);
      PH_RST_LOW:  drive = 1'b1;
      PH_GAP_FAIL: done  = 1'b1;
      PH_WRITE: begin
        drive = shift_q[0] ? (tick_q < TickOne) : (tick_q < SlotM1);
        done  = slot_end && (bit_inc == 3'd0) && (byte_inc >= n_bytes)
                && (kind_q != CMD_READ);
      end
      PH_READ: begin
        drive = (tick_q == '0);
        done  = slot_end && (bit_inc == 3'd0) && (byte_q != 3'd0);
      end
      default: begin
        drive = 1'b0;
        done  = 1'b0;
      end
    endcase
  end

  assign res_o.drive_low   = drive;
  assign res_o.busy        = (phase_d != PH_IDLE);
  assign res_o.done        = done;
  assign res_o.present     = present_d;
  assign res_o.temperature = reading_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      tick_q    <= '0;
      bit_q     <= '0;
      byte_q    <= '0;
      kind_q    <= '0;
      shift_q   <= '0;
      reading_q <= NO_READING;
      present_q <= 1'b0;
      low_q     <= '0;
    end else if (step_i) begin
      phase_q   <= phase_d;
      tick_q    <= tick_d;
      bit_q     <= bit_d;
      byte_q    <= byte_d;
      kind_q    <= kind_d;
      shift_q   <= shift_d;
      reading_q <= reading_d;
      present_q <= present_d;
      low_q     <= low_d;
    end
  end

endmodule
`default_nettype wire

[design/onewire_temperature_sensor_master_top.sv]
// One-wire temperature sensor bus master. Each input request is one 5 us bus
// tick: the sampled line level plus an optional command (1 convert, 2 read
// temperature, 3 write alarm word and setup byte); each request yields exactly
// one result request telling whether to pull the bus low during that tick,
// plus busy, done, presence and the last temperature reading (0x7FFF when no
// device answered a read). Commands that arrive while busy are ignored. The
// block takes one tick request per clock cycle: the per-tick sequencer is a
// single pass of logic from its state registers into the result register, so
// a result appears in the cycle after its tick is accepted, and the input is
// stalled only while a result is held because the output side stalls.
// Configuration writes (index 0 alarm word, index 1 setup byte) are always
// ready and take effect for bytes not yet loaded. No clearing pass after reset.
`default_nettype none
module onewire_temperature_sensor_master_top import owtm_pkg::*; #(
  parameter int unsigned RESET_LOW_TICKS     = RESET_LOW_TICKS_DEF,
  parameter int unsigned PRESENCE_WAIT_TICKS = PRESENCE_WAIT_TICKS_DEF,
  parameter int unsigned RECOVERY_WAIT_TICKS = RECOVERY_WAIT_TICKS_DEF,
  parameter int unsigned SLOT_TICKS          = SLOT_TICKS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // tick requests
  input  wire logic        in_valid_i,
  output      logic        in_stall_o,
  input  wire logic [1:0]  command_i,
  input  wire logic        line_level_i,
  // result requests
  output      logic        out_valid_o,
  input  wire logic        out_stall_i,
  output      logic        drive_low_o,
  output      logic        busy_res_o,
  output      logic        done_res_o,
  output      logic        device_present_o,
  output      logic [15:0] temperature_o,
  // config writes
  input  wire logic        cfg_valid_i,
  output      logic        cfg_ready_o,
  input  wire logic        cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);

`include "onewire_temperature_sensor_master_top_assert.svh"

  logic        accept;
  logic        out_valid_q, out_valid_d;
  res_t        res, res_q;
  logic [15:0] alarm_word_q;
  logic [7:0]  setup_byte_q;

  // stall only when a finished result is still waiting
  assign in_stall_o  = out_valid_q & out_stall_i;
  assign accept      = in_valid_i & ~in_stall_o;
  assign cfg_ready_o = 1'b1;

  owtm_core #(
    .RESET_LOW_TICKS     (RESET_LOW_TICKS),
    .PRESENCE_WAIT_TICKS (PRESENCE_WAIT_TICKS),
    .RECOVERY_WAIT_TICKS (RECOVERY_WAIT_TICKS),
    .SLOT_TICKS          (SLOT_TICKS)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (accept),
    .command_i    (command_i),
    .line_level_i (line_level_i),
    .alarm_word_i (alarm_word_q),
    .setup_byte_i (setup_byte_q),
    .res_o        (res)
  );

  // result register: loads on accept, empties when taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (accept)            out_valid_d = 1'b1;
    else if (!out_stall_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) res_q <= res;
  end

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alarm_word_q <= '0;
      setup_byte_q <= SETUP_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_ALARM_WORD: alarm_word_q <= cfg_data_i;
        CFG_SETUP_BYTE: setup_byte_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  assign out_valid_o      = out_valid_q;
  assign drive_low_o      = res_q.drive_low;
  assign busy_res_o       = res_q.busy;
  assign done_res_o       = res_q.done;
  assign device_present_o = res_q.present;
  assign temperature_o    = res_q.temperature;

  `OWTM_ASSERT_NEXT(a_accept_gives_result, accept, out_valid_o, "accepted tick left no result")
  `OWTM_ASSERT_NOW(a_no_stall_when_empty, !out_valid_o, !in_stall_o, "stall with empty output")
  `OWTM_ASSERT_NOW(a_done_not_busy, out_valid_o && done_res_o, !busy_res_o, "done while busy")
  `OWTM_ASSERT_NOW(a_done_released, out_valid_o && done_res_o, !drive_low_o, "bus driven on done")

endmodule
`default_nettype wire
